/* src/hsvrgb_pkg.sv */
// ============================================================================
// hsvrgb_pkg - shared types and constants of the HSV to RGB converter
// Fixed-point formats, payload structs and pipeline stage records.
// ============================================================================
package hsvrgb_pkg;

    // Q1.15 one, full hue circle and one sector, all in input units
    localparam logic [15:0] Q_ONE      = 16'd32768;
    localparam logic [15:0] HUE_FULL   = 16'd23040;
    localparam int          REM_W      = 12;
    localparam logic [REM_W-1:0] HUE_SECTOR = 12'd3840;

    // remainder / 3840 = (x >> 8) / 15, the /15 done by reciprocal multiply
    localparam int          PROD_W      = 27;
    localparam int          PRE_SHIFT   = 8;
    localparam int          DIVIDEND_W  = PROD_W - PRE_SHIFT;
    localparam int          RECIP_W     = 21;
    localparam int          RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP15 = 21'd1118482;
    localparam int          QMUL_W      = DIVIDEND_W + RECIP_W;

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] saturation;
        logic [15:0] brightness;
    } t_hsv;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_rgb;

    // after hue split and clamping
    typedef struct packed {
        t_sector          sector;
        logic [REM_W-1:0] rem;
        logic [15:0]      sat;
        logic [15:0]      val;
    } t_split;

    // raw saturation products and level p
    typedef struct packed {
        t_sector           sector;
        logic [PROD_W-1:0] sf_prod;
        logic [PROD_W-1:0] sg_prod;
        logic [15:0]       lvl_p;
        logic [15:0]       val;
    } t_prod;

    // s*f and s*(1-f) in Q1.15
    typedef struct packed {
        t_sector     sector;
        logic [15:0] sf;
        logic [15:0] sg;
        logic [15:0] lvl_p;
        logic [15:0] val;
    } t_frac;

    // all four levels ready for routing
    typedef struct packed {
        t_sector     sector;
        logic [15:0] lvl_p;
        logic [15:0] lvl_q;
        logic [15:0] lvl_t;
        logic [15:0] val;
    } t_level;

endpackage

/* src/hsvrgb_split.sv */
// ============================================================================
// hsvrgb_split - hue sector split and input clamping
// Maps hues of 360 degrees and above to 0, finds sector and remainder, clamps s, v.
// ============================================================================
module hsvrgb_split (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hsvrgb_pkg::t_hsv    i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output hsvrgb_pkg::t_split  o_data
);

    logic               r_valid;
    hsvrgb_pkg::t_split r_data;
    hsvrgb_pkg::t_split n_data;
    logic [15:0]        hue_w;
    logic [15:0]        base;
    logic [15:0]        rem_full;

    always_comb begin
        hue_w = (i_data.hue >= hsvrgb_pkg::HUE_FULL) ? 16'd0 : i_data.hue;
        priority if (hue_w < 16'd3840) begin
            n_data.sector = hsvrgb_pkg::SEC_R_TO_Y;
            base          = 16'd0;
        end else if (hue_w < 16'd7680) begin
            n_data.sector = hsvrgb_pkg::SEC_Y_TO_G;
            base          = 16'd3840;
        end else if (hue_w < 16'd11520) begin
            n_data.sector = hsvrgb_pkg::SEC_G_TO_C;
            base          = 16'd7680;
        end else if (hue_w < 16'd15360) begin
            n_data.sector = hsvrgb_pkg::SEC_C_TO_B;
            base          = 16'd11520;
        end else if (hue_w < 16'd19200) begin
            n_data.sector = hsvrgb_pkg::SEC_B_TO_M;
            base          = 16'd15360;
        end else begin
            n_data.sector = hsvrgb_pkg::SEC_M_TO_R;
            base          = 16'd19200;
        end
        rem_full   = hue_w - base;
        n_data.rem = rem_full[hsvrgb_pkg::REM_W-1:0];
        n_data.sat = (i_data.saturation > hsvrgb_pkg::Q_ONE) ? hsvrgb_pkg::Q_ONE
                                                             : i_data.saturation;
        n_data.val = (i_data.brightness > hsvrgb_pkg::Q_ONE) ? hsvrgb_pkg::Q_ONE
                                                             : i_data.brightness;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* src/hsvrgb_frac.sv */
// ============================================================================
// hsvrgb_frac - saturation times hue fraction
// Two stages: raw products with level p, then divide by the sector width.
// ============================================================================
module hsvrgb_frac (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hsvrgb_pkg::t_split  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output hsvrgb_pkg::t_frac   o_data
);

    logic              r_vld_prod;
    logic              r_vld_frac;
    logic              rdy_prod;
    logic              rdy_frac;
    hsvrgb_pkg::t_prod r_prod;
    hsvrgb_pkg::t_prod n_prod;
    hsvrgb_pkg::t_frac r_frac;
    hsvrgb_pkg::t_frac n_frac;

    logic [hsvrgb_pkg::REM_W-1:0]      rem_c;
    logic [hsvrgb_pkg::REM_W+15:0]     sf_wide;
    logic [hsvrgb_pkg::REM_W+15:0]     sg_wide;
    logic [31:0]                       p_wide;
    logic [15:0]                       one_m_s;
    logic [hsvrgb_pkg::DIVIDEND_W-1:0] sf_div;
    logic [hsvrgb_pkg::DIVIDEND_W-1:0] sg_div;
    logic [hsvrgb_pkg::QMUL_W-1:0]     sf_quo;
    logic [hsvrgb_pkg::QMUL_W-1:0]     sg_quo;

    // stage A: s*rem, s*(3840-rem), p = v*(1-s)
    always_comb begin
        rem_c          = hsvrgb_pkg::HUE_SECTOR - i_data.rem;
        one_m_s        = hsvrgb_pkg::Q_ONE - i_data.sat;
        sf_wide        = i_data.sat * i_data.rem;
        sg_wide        = i_data.sat * rem_c;
        p_wide         = i_data.val * one_m_s;
        n_prod.sector  = i_data.sector;
        n_prod.sf_prod = sf_wide[hsvrgb_pkg::PROD_W-1:0];
        n_prod.sg_prod = sg_wide[hsvrgb_pkg::PROD_W-1:0];
        n_prod.lvl_p   = p_wide[30:15];
        n_prod.val     = i_data.val;
    end

    // stage B: floor(x / 3840) = floor((x >> 8) * ceil(2^24/15) >> 24)
    always_comb begin
        sf_div = r_prod.sf_prod[hsvrgb_pkg::PROD_W-1:hsvrgb_pkg::PRE_SHIFT];
        sg_div = r_prod.sg_prod[hsvrgb_pkg::PROD_W-1:hsvrgb_pkg::PRE_SHIFT];
        sf_quo = hsvrgb_pkg::QMUL_W'(sf_div) * hsvrgb_pkg::QMUL_W'(hsvrgb_pkg::RECIP15);
        sg_quo = hsvrgb_pkg::QMUL_W'(sg_div) * hsvrgb_pkg::QMUL_W'(hsvrgb_pkg::RECIP15);
        n_frac.sector = r_prod.sector;
        n_frac.sf     = sf_quo[hsvrgb_pkg::RECIP_SHIFT+15:hsvrgb_pkg::RECIP_SHIFT];
        n_frac.sg     = sg_quo[hsvrgb_pkg::RECIP_SHIFT+15:hsvrgb_pkg::RECIP_SHIFT];
        n_frac.lvl_p  = r_prod.lvl_p;
        n_frac.val    = r_prod.val;
    end

    assign rdy_frac = !r_vld_frac || i_ready;
    assign rdy_prod = !r_vld_prod || rdy_frac;
    assign o_ready  = rdy_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_prod <= 1'b0;
            r_vld_frac <= 1'b0;
        end else begin
            if (rdy_prod) begin
                r_vld_prod <= i_valid;
            end
            if (rdy_frac) begin
                r_vld_frac <= r_vld_prod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_prod && i_valid) begin
            r_prod <= n_prod;
        end
        if (rdy_frac && r_vld_prod) begin
            r_frac <= n_frac;
        end
    end

    assign o_valid = r_vld_frac;
    assign o_data  = r_frac;

endmodule

/* src/hsvrgb_route.sv */
// ============================================================================
// hsvrgb_route - levels q and t, sector routing, output register
// Two stages: the value products, then the RGB select into the output.
// ============================================================================
module hsvrgb_route (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hsvrgb_pkg::t_frac   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output hsvrgb_pkg::t_rgb    o_data
);

    logic               r_vld_lvl;
    logic               r_vld_out;
    logic               rdy_lvl;
    logic               rdy_out;
    hsvrgb_pkg::t_level r_lvl;
    hsvrgb_pkg::t_level n_lvl;
    hsvrgb_pkg::t_rgb   r_out;
    hsvrgb_pkg::t_rgb   n_out;
    logic [15:0]        one_m_sf;
    logic [15:0]        one_m_sg;
    logic [31:0]        q_wide;
    logic [31:0]        t_wide;

    always_comb begin
        one_m_sf     = hsvrgb_pkg::Q_ONE - i_data.sf;
        one_m_sg     = hsvrgb_pkg::Q_ONE - i_data.sg;
        q_wide       = i_data.val * one_m_sf;
        t_wide       = i_data.val * one_m_sg;
        n_lvl.sector = i_data.sector;
        n_lvl.lvl_p  = i_data.lvl_p;
        n_lvl.lvl_q  = q_wide[30:15];
        n_lvl.lvl_t  = t_wide[30:15];
        n_lvl.val    = i_data.val;
    end

    always_comb begin
        unique case (r_lvl.sector)
            hsvrgb_pkg::SEC_R_TO_Y: n_out = '{r_lvl.val,   r_lvl.lvl_t, r_lvl.lvl_p};
            hsvrgb_pkg::SEC_Y_TO_G: n_out = '{r_lvl.lvl_q, r_lvl.val,   r_lvl.lvl_p};
            hsvrgb_pkg::SEC_G_TO_C: n_out = '{r_lvl.lvl_p, r_lvl.val,   r_lvl.lvl_t};
            hsvrgb_pkg::SEC_C_TO_B: n_out = '{r_lvl.lvl_p, r_lvl.lvl_q, r_lvl.val};
            hsvrgb_pkg::SEC_B_TO_M: n_out = '{r_lvl.lvl_t, r_lvl.lvl_p, r_lvl.val};
            default:                n_out = '{r_lvl.val,   r_lvl.lvl_p, r_lvl.lvl_q};
        endcase
    end

    assign rdy_out = !r_vld_out || i_ready;
    assign rdy_lvl = !r_vld_lvl || rdy_out;
    assign o_ready = rdy_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_lvl <= 1'b0;
            r_vld_out <= 1'b0;
        end else begin
            if (rdy_lvl) begin
                r_vld_lvl <= i_valid;
            end
            if (rdy_out) begin
                r_vld_out <= r_vld_lvl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_lvl && i_valid) begin
            r_lvl <= n_lvl;
        end
        if (rdy_out && r_vld_lvl) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vld_out;
    assign o_data  = r_out;

endmodule

/* src/hsv_to_rgb_converter_unit.sv */
// ============================================================================
// hsv_to_rgb_converter_unit - fixed-point HSV to RGB pixel converter
// Five-stage pipeline, one pixel in and one pixel out per clock.
// ============================================================================
//
//  Channel   Direction  Handshake            Request
//  --------  ---------  -------------------  -------------------------------
//  i_hsv     in         i_valid / o_ready    hue, saturation, brightness
//  o_rgb     out        o_valid / i_ready    red, green, blue (Q1.15)
//
//  A request passes the split, prod, frac, lvl and out registers in turn;
//  a new request is taken every cycle while the consumer keeps i_ready high.
//  Depth is set by the multiplier chain: s*f, the divide by the sector
//  width (reciprocal multiply), v*(1-x), then the sector select.
//  Synchronous active-low reset clears only the stage valid bits.
//  Each stage holds its request while the stage after it is full and
//  stalled, and loads whenever it is empty, so bubbles close up.
//
module hsv_to_rgb_converter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hsvrgb_pkg::t_hsv  i_hsv,
    output logic              o_valid,
    input  logic              i_ready,
    output hsvrgb_pkg::t_rgb  o_rgb
);

    logic               split_valid;
    logic               split_ready;
    hsvrgb_pkg::t_split split_data;
    logic               frac_valid;
    logic               frac_ready;
    hsvrgb_pkg::t_frac  frac_data;

    // stage 1: wrap hue, split into sector and remainder, clamp s and v
    hsvrgb_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_hsv),
        .o_valid (split_valid),
        .i_ready (split_ready),
        .o_data  (split_data)
    );

    // stages 2 and 3: s*f, s*(1-f) and p
    hsvrgb_frac u_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (split_valid),
        .o_ready (split_ready),
        .i_data  (split_data),
        .o_valid (frac_valid),
        .i_ready (frac_ready),
        .o_data  (frac_data)
    );

    // stages 4 and 5: q and t, then route by sector into the output register
    hsvrgb_route u_route (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (frac_valid),
        .o_ready (frac_ready),
        .i_data  (frac_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_rgb)
    );

    // drop all requests in flight on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // every component stays within Q1.15 one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rgb.red <= hsvrgb_pkg::Q_ONE) && (o_rgb.green <= hsvrgb_pkg::Q_ONE)
                    && (o_rgb.blue <= hsvrgb_pkg::Q_ONE))
        else $error("color component above one");

    // a ready consumer never back-pressures the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input stalled while output side is ready");

    // input stalls only when the first stage holds a request
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> split_valid && !split_ready)
        else $error("input stalled with first stage free");

endmodule
